@@ hdl/assert_macros.svh @@
// Assertion macros for the CHIP-8 core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suppressed while reset is high.
`define C8_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define C8_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/c8cpu_pkg.sv @@
// Types, constants and helper functions for the CHIP-8 core.
`default_nettype none
package c8cpu_pkg;

  localparam int RAM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int AW = $clog2(RAM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  localparam int FONT_BYTES = 'h50;
  localparam logic [11:0] START_PC = 12'h200;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STACK   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [4:0]  row_index;
    logic [3:0]  key_code;
    logic        key_down;
    logic [7:0]  random_byte;
  } in_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] opcode;
    logic        draw_flag;
    logic        sound_on;
    logic [63:0] row_bits;
    logic [1:0]  status;
  } out_t;

  // Controller steps; the current step is also the command to the datapath.
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_READ,
    S_FETCH0, S_FETCH1, S_FETCH2, S_RDX, S_RDY, S_EXEC,
    S_FLAG, S_POP, S_DRAW_RD, S_DRAW_WR, S_DRAW_END,
    S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_FIN, S_DONE
  } step_t;

  typedef enum logic [2:0] {
    INS_SIMPLE, INS_ALUF, INS_RET, INS_DRAW, INS_BCD, INS_STORE, INS_LOAD
  } ins_t;

  typedef struct packed {
    step_t step;
    logic  accept;
  } cmd_t;

  typedef struct packed {
    ins_t cls;
    logic stk_empty;
    logic n_zero;
    logic last;
    logic clr_last;
  } stat_t;

  function automatic ins_t ins_class(input logic [15:0] op);
    ins_t c;
    c = INS_SIMPLE;
    unique case (op[15:12])
      4'h0: if (op == 16'h00EE) c = INS_RET;
      4'h8: begin
        case (op[3:0]) inside
          4'h4, 4'h5, 4'h6, 4'h7, 4'hE: c = INS_ALUF;
          default: c = INS_SIMPLE;
        endcase
      end
      4'hD: c = INS_DRAW;
      4'hF: begin
        case (op[7:0])
          8'h33:   c = INS_BCD;
          8'h55:   c = INS_STORE;
          8'h65:   c = INS_LOAD;
          default: c = INS_SIMPLE;
        endcase
      end
      default: c = INS_SIMPLE;
    endcase
    return c;
  endfunction

  // Decimal digit of v: sel 0 hundreds, 1 tens, 2 ones.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0] h;
    logic [6:0] r;
    logic [3:0] t;
    logic [6:0] o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h) * 8'd100);
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 7'(k * 10)) t = 4'(k);
    end
    o = 7'(r - 7'(t) * 7'd10);
    case (sel)
      2'd0:    bcd_digit = {6'd0, h};
      2'd1:    bcd_digit = {4'd0, t};
      default: bcd_digit = {1'b0, o};
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/chip8_cpu_core.sv @@
// Top level of the CHIP-8 processor core.
`default_nettype none
// Items are taken on start while busy is low; each item gives one result on
// result, shown for exactly one cycle with done high, and the receiver cannot
// stall it. After reset a clearing pass writes the font and zeroes RAM, with
// busy high. A step fetches the opcode, reads its registers and executes it;
// a flag write, a return from a non-empty stack, a sprite of N rows, BCD and
// register block store or load add states before the result. Busy is low
// again in the cycle after the result, so the next item can be taken then.
// The RAM and register file each have one read port and one write port.
module chip8_cpu_core
  import c8cpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  item,
  output logic      done,
  output out_t      result
);

  cmd_t  cmd;
  stat_t stat;

  c8cpu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (item.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  c8cpu_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .stat (stat),
    .res  (result)
  );

endmodule
`default_nettype wire

@@ hdl/c8cpu_ctrl.sv @@
// Sequencing state machine of the CHIP-8 core.
`default_nettype none
`include "assert_macros.svh"
module c8cpu_ctrl
  import c8cpu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] mode,
  input  wire stat_t      stat,
  output cmd_t            cmd,
  output logic            busy,
  output logic            done
);

  step_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.step   = state;
    cmd.accept = 1'b0;
    busy       = (state != S_IDLE);
    done       = (state == S_DONE);
    unique case (state)
      S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (mode)
            MODE_LOAD: state_next = S_LOAD;
            MODE_STEP: state_next = S_FETCH0;
            MODE_READ: state_next = S_READ;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_LOAD:   state_next = S_DONE;
      S_READ:   state_next = S_DONE;
      S_FETCH0: state_next = S_FETCH1;
      S_FETCH1: state_next = S_FETCH2;
      S_FETCH2: state_next = S_RDX;
      S_RDX:    state_next = S_RDY;
      S_RDY:    state_next = S_EXEC;
      S_EXEC: begin
        unique case (stat.cls)
          INS_ALUF:  state_next = S_FLAG;
          INS_RET:   state_next = stat.stk_empty ? S_FIN : S_POP;
          INS_DRAW:  state_next = stat.n_zero ? S_DRAW_END : S_DRAW_RD;
          INS_BCD:   state_next = S_BCD;
          INS_STORE: state_next = S_ST_RD;
          INS_LOAD:  state_next = S_LD_RD;
          default:   state_next = S_FIN;
        endcase
      end
      S_FLAG:     state_next = S_FIN;
      S_POP:      state_next = S_FIN;
      S_DRAW_RD:  state_next = S_DRAW_WR;
      S_DRAW_WR:  state_next = stat.last ? S_DRAW_END : S_DRAW_RD;
      S_DRAW_END: state_next = S_FIN;
      S_BCD:      state_next = stat.last ? S_FIN : S_BCD;
      S_ST_RD:    state_next = S_ST_WR;
      S_ST_WR:    state_next = stat.last ? S_FIN : S_ST_RD;
      S_LD_RD:    state_next = S_LD_WR;
      S_LD_WR:    state_next = stat.last ? S_FIN : S_LD_RD;
      S_FIN:      state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  `C8_ASSERT(a_done_to_idle, done |=> !busy, "result strobe not followed by idle")
  `C8_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not make core busy")
  `C8_ASSERT(a_draw_loop, (state == S_DRAW_WR && !stat.last) |=> (state == S_DRAW_RD), "sprite row loop ended early")
  `C8_ASSERT_ALWAYS(a_reset_clear, rst |=> (state == S_CLEAR), "reset did not start clearing")

endmodule
`default_nettype wire

@@ hdl/c8cpu_dp.sv @@
// Datapath of the CHIP-8 core: RAM, registers, stack, frame buffer and ALU.
`default_nettype none
module c8cpu_dp
  import c8cpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  item,
  input  wire cmd_t cmd,
  output stat_t     stat,
  output out_t      res
);

  // storage
  logic [7:0]  ram [RAM_BYTES];
  logic [7:0]  ram_q;
  logic [7:0]  rf [16];
  logic [15:0] rf_vld;
  logic [7:0]  rf_raw;
  logic        rf_vq;
  logic [11:0] stk [STACK_DEPTH];
  logic [11:0] stk_q;
  logic [63:0] fb [32];

  // architectural and working registers
  in_t         itm;
  logic [11:0] pc;
  logic [15:0] op;
  logic [7:0]  op_hi;
  logic [7:0]  vx, vy;
  logic [15:0] ireg;
  logic [7:0]  dt, snd;
  logic        changed;
  logic [DW-1:0] depth;
  logic [1:0]  status;
  logic        drawf;
  logic [63:0] row_q;
  logic        flag_q;
  logic        coll;
  logic [3:0]  cnt;
  logic [AW-1:0] clr_cnt;

  // port controls
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0]    ram_wd;
  logic          rf_we;
  logic [3:0]    rf_wa, rf_ra;
  logic [7:0]    rf_wd;
  logic          stk_we;
  logic [SW-1:0] stk_ra;

  logic [7:0]    rf_q, vyw;
  logic [3:0]    xi, yi, ni;
  logic [7:0]    nn;
  logic [11:0]   nnn;
  logic [AW-1:0] i_addr;
  logic          alu_we, alu_flag;
  logic [7:0]    alu_val;
  logic [8:0]    sum9;
  logic [4:0]    drow;
  logic [127:0]  rot;
  logic [63:0]   smask;
  ins_t          cls;

  assign xi     = op[11:8];
  assign yi     = op[7:4];
  assign ni     = op[3:0];
  assign nn     = op[7:0];
  assign nnn    = op[11:0];
  assign rf_q   = rf_vq ? rf_raw : 8'd0;
  assign vyw    = rf_q;
  assign i_addr = AW'(ireg + {12'd0, cnt});
  assign cls    = ins_class(op);
  assign sum9   = {1'b0, vx} + {1'b0, vyw};

  // sprite row placed at column vx, wrapping around the 64-pixel line
  assign drow  = 5'(vy[4:0] + {1'b0, cnt});
  assign rot   = {ram_q, 56'd0, ram_q, 56'd0} >> vx[5:0];
  assign smask = rot[63:0];

  always_comb begin
    stat.cls       = cls;
    stat.stk_empty = (depth == '0);
    stat.n_zero    = (ni == 4'd0);
    stat.clr_last  = (clr_cnt == AW'(RAM_BYTES - 1));
    case (cls)
      INS_DRAW: stat.last = (cnt == 4'(ni - 4'd1));
      INS_BCD:  stat.last = (cnt == 4'd2);
      default:  stat.last = (cnt == xi);
    endcase
  end

  always_comb begin
    alu_we   = 1'b0;
    alu_val  = 8'd0;
    alu_flag = 1'b0;
    case (op[15:12])
      4'h6: begin alu_we = 1'b1; alu_val = nn; end
      4'h7: begin alu_we = 1'b1; alu_val = 8'(vx + nn); end
      4'h8: begin
        alu_we = 1'b1;
        case (ni)
          4'h0: alu_val = vyw;
          4'h1: alu_val = vx | vyw;
          4'h2: alu_val = vx & vyw;
          4'h3: alu_val = vx ^ vyw;
          4'h4: begin alu_val = sum9[7:0]; alu_flag = sum9[8]; end
          4'h5: begin alu_val = 8'(vx - vyw); alu_flag = (vx >= vyw); end
          4'h6: begin alu_val = {1'b0, vx[7:1]}; alu_flag = vx[0]; end
          4'h7: begin alu_val = 8'(vyw - vx); alu_flag = (vyw >= vx); end
          4'hE: begin alu_val = {vx[6:0], 1'b0}; alu_flag = vx[7]; end
          default: alu_we = 1'b0;
        endcase
      end
      4'hC: begin alu_we = 1'b1; alu_val = itm.random_byte & nn; end
      4'hF: if (nn == 8'h07) begin alu_we = 1'b1; alu_val = dt; end
      default: alu_we = 1'b0;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = clr_cnt;
    ram_wd = 8'd0;
    ram_ra = pc[AW-1:0];
    rf_we  = 1'b0;
    rf_wa  = xi;
    rf_wd  = alu_val;
    rf_ra  = xi;
    stk_we = 1'b0;
    stk_ra = SW'(depth - DW'(1));
    unique case (cmd.step)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt < AW'(FONT_BYTES)) ram_wd = FONT_ROM[clr_cnt[6:0]];
      end
      S_LOAD: begin
        ram_we = 1'b1;
        ram_wa = itm.load_address[AW-1:0];
        ram_wd = itm.load_byte;
      end
      S_FETCH1: ram_ra = AW'(pc + 12'd1);
      S_RDX:    rf_ra  = (op[15:12] == 4'hB) ? 4'd0 : xi;
      S_RDY:    rf_ra  = yi;
      S_EXEC: begin
        rf_we  = alu_we;
        stk_we = (op[15:12] == 4'h2) && (depth != DW'(STACK_DEPTH));
      end
      S_FLAG:     begin rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'd0, flag_q}; end
      S_DRAW_RD:  ram_ra = i_addr;
      S_DRAW_END: begin rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'd0, coll}; end
      S_BCD: begin
        ram_we = 1'b1;
        ram_wa = i_addr;
        ram_wd = bcd_digit(vx, cnt[1:0]);
      end
      S_ST_RD: rf_ra = cnt;
      S_ST_WR: begin ram_we = 1'b1; ram_wa = i_addr; ram_wd = rf_q; end
      S_LD_RD: ram_ra = i_addr;
      S_LD_WR: begin rf_we = 1'b1; rf_wa = cnt; rf_wd = ram_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_wa] <= ram_wd;
    ram_q <= ram[ram_ra];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    rf_raw <= rf[rf_ra];
    rf_vq  <= rf_vld[rf_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[depth[SW-1:0]] <= pc;
    stk_q <= stk[stk_ra];
  end

  // item and working values
  always_ff @(posedge clk) begin
    if (cmd.accept) itm <= item;
    unique case (cmd.step)
      S_FETCH1: op_hi <= ram_q;
      S_FETCH2: op    <= {op_hi, ram_q};
      S_RDY:    vx    <= rf_q;
      S_EXEC: begin
        vy     <= vyw;
        flag_q <= alu_flag;
        cnt    <= 4'd0;
        coll   <= 1'b0;
      end
      S_DRAW_WR: begin
        coll <= coll | (|(fb[drow] & smask));
        cnt  <= 4'(cnt + 4'd1);
      end
      S_BCD, S_ST_WR, S_LD_WR: cnt <= 4'(cnt + 4'd1);
      default: ;
    endcase
    if (cmd.accept) op <= 16'd0;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld  <= '0;
      pc      <= START_PC;
      ireg    <= 16'd0;
      dt      <= 8'd0;
      snd     <= 8'd0;
      changed <= 1'b0;
      depth   <= '0;
      status  <= ST_OK;
      drawf   <= 1'b0;
      row_q   <= 64'd0;
      clr_cnt <= '0;
      for (int r = 0; r < 32; r++) fb[r] <= 64'd0;
    end else begin
      if (rf_we) rf_vld[rf_wa] <= 1'b1;
      if (cmd.accept) begin
        status <= ST_OK;
        row_q  <= 64'd0;
        drawf  <= changed;
      end
      unique case (cmd.step)
        S_CLEAR:  clr_cnt <= AW'(clr_cnt + AW'(1));
        S_READ: begin
          row_q <= fb[itm.row_index];
          if (itm.row_index == 5'd0) changed <= 1'b0;
        end
        S_FETCH2: pc <= 12'(pc + 12'd2);
        S_EXEC: begin
          unique case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) begin
                for (int r = 0; r < 32; r++) fb[r] <= 64'd0;
                changed <= 1'b1;
              end else if (op == 16'h00EE) begin
                if (depth == '0) status <= ST_STACK;
                else             depth  <= DW'(depth - DW'(1));
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (depth == DW'(STACK_DEPTH)) status <= ST_STACK;
              else begin
                depth <= DW'(depth + DW'(1));
                pc    <= nnn;
              end
            end
            4'h3: if (vx == nn)  pc <= 12'(pc + 12'd2);
            4'h4: if (vx != nn)  pc <= 12'(pc + 12'd2);
            4'h5: if (vx == vyw) pc <= 12'(pc + 12'd2);
            4'h9: if (vx != vyw) pc <= 12'(pc + 12'd2);
            4'hA: ireg <= {4'd0, nnn};
            4'hB: pc <= 12'({4'd0, vx} + nnn);
            4'h8: if (ni inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hF})
                    status <= ST_UNKNOWN;
            4'hE: begin
              if (nn == 8'h9E) begin
                if (itm.key_down && ({4'd0, itm.key_code} == vx)) pc <= 12'(pc + 12'd2);
              end else if (nn == 8'hA1) begin
                if (!(itm.key_down && ({4'd0, itm.key_code} == vx)))
                  pc <= 12'(pc + 12'd2);
              end else begin
                status <= ST_UNKNOWN;
              end
            end
            4'hF: begin
              case (nn)
                8'h07, 8'h0A, 8'h33, 8'h55, 8'h65: ;
                8'h15:   dt   <= vx;
                8'h18:   snd  <= vx;
                8'h1E:   ireg <= 16'(ireg + {8'd0, vx});
                8'h29:   ireg <= 16'({12'd0, vx[3:0]} * 16'd5);
                default: status <= ST_UNKNOWN;
              endcase
            end
            default: ;
          endcase
        end
        S_POP:      pc <= stk_q;
        S_DRAW_WR:  fb[drow] <= fb[drow] ^ smask;
        S_DRAW_END: changed <= 1'b1;
        S_FIN: begin
          if (dt != 8'd0)  dt  <= 8'(dt - 8'd1);
          if (snd != 8'd0) snd <= 8'(snd - 8'd1);
          drawf <= changed;
        end
        default: ;
      endcase
    end
  end

  assign res.program_counter = pc;
  assign res.opcode          = op;
  assign res.draw_flag       = drawf;
  assign res.sound_on        = (snd != 8'd0);
  assign res.row_bits        = row_q;
  assign res.status          = status;

endmodule
`default_nettype wire

@@ bench/chip8_checker.sv @@
// Checker for the CHIP-8 core: predicts each result and compares it with the core's output.
module chip8_checker
  import c8cpu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  in_t  item,
  input  logic done,
  input  out_t result,
  output int   fail_count,
  output int   pending
);

  logic [7:0]  ram [RAM_BYTES];
  logic [63:0] frame [32];
  logic [7:0]  vreg [16];
  logic [11:0] ret_stack [STACK_DEPTH];
  int          depth;
  logic [11:0] pc;
  logic [15:0] idx;
  logic [7:0]  delay_t, sound_t;
  logic        changed;
  out_t        expected_q[$];
  int          mismatches;

  function automatic logic [11:0] skip(input logic [11:0] p);
    return p + 12'd2;
  endfunction

  // Executes one instruction on the predictor state and returns its status.
  function automatic logic [1:0] exec_op(input logic [15:0] op, input in_t it);
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, line;
    logic [8:0] sum;
    logic       flag, hit;
    int         col, row;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
    vx = vreg[x]; vy = vreg[y];
    flag = 1'b0;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (int r = 0; r < 32; r++) frame[r] = '0;
          changed = 1'b1;
        end else if (op == 16'h00EE) begin
          if (depth == 0) return ST_STACK;
          depth--;
          pc = ret_stack[depth];
        end
      end
      4'h1: pc = op[11:0];
      4'h2: begin
        if (depth >= STACK_DEPTH) return ST_STACK;
        ret_stack[depth] = pc;
        depth++;
        pc = op[11:0];
      end
      4'h3: if (vx == nn) pc = skip(pc);
      4'h4: if (vx != nn) pc = skip(pc);
      4'h5: if (vx == vy) pc = skip(pc);
      4'h6: vreg[x] = nn;
      4'h7: vreg[x] = vx + nn;
      4'h8: begin
        case (n)
          4'h0: vreg[x] = vy;
          4'h1: vreg[x] = vx | vy;
          4'h2: vreg[x] = vx & vy;
          4'h3: vreg[x] = vx ^ vy;
          4'h4: begin sum = vx + vy; vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]}; end
          4'h5: begin flag = vx >= vy; vreg[x] = vx - vy; vreg[15] = {7'd0, flag}; end
          4'h6: begin vreg[x] = vx >> 1; vreg[15] = {7'd0, vx[0]}; end
          4'h7: begin flag = vy >= vx; vreg[x] = vy - vx; vreg[15] = {7'd0, flag}; end
          4'hE: begin vreg[x] = vx << 1; vreg[15] = {7'd0, vx[7]}; end
          default: return ST_UNKNOWN;
        endcase
      end
      4'h9: if (vx != vy) pc = skip(pc);
      4'hA: idx = {4'd0, op[11:0]};
      4'hB: pc = {4'd0, vreg[0]} + op[11:0];
      4'hC: vreg[x] = it.random_byte & nn;
      4'hD: begin
        vreg[15] = 8'd0;
        for (int r = 0; r < n; r++) begin
          line = ram[(idx + r) % RAM_BYTES];
          row = (vy + r) & 31;
          for (int c = 0; c < 8; c++)
            if (line[7-c]) begin
              col = (vx + c) & 63;
              if (frame[row][63-col]) vreg[15] = 8'd1;
              frame[row][63-col] = ~frame[row][63-col];
            end
        end
        changed = 1'b1;
      end
      4'hE: begin
        hit = it.key_down && ({4'd0, it.key_code} == vx);
        if (nn == 8'h9E) begin
          if (hit) pc = skip(pc);
        end else if (nn == 8'hA1) begin
          if (!hit) pc = skip(pc);
        end else return ST_UNKNOWN;
      end
      default: begin
        case (nn)
          8'h07: vreg[x] = delay_t;
          8'h0A: ;
          8'h15: delay_t = vx;
          8'h18: sound_t = vx;
          8'h1E: idx = idx + vx;
          8'h29: idx = 16'(vx[3:0] * 5);
          8'h33: begin
            ram[idx % RAM_BYTES] = vx / 100;
            ram[(idx + 1) % RAM_BYTES] = (vx / 10) % 10;
            ram[(idx + 2) % RAM_BYTES] = vx % 10;
          end
          8'h55: for (int i = 0; i <= x; i++) ram[(idx + i) % RAM_BYTES] = vreg[i];
          8'h65: for (int i = 0; i <= x; i++) vreg[i] = ram[(idx + i) % RAM_BYTES];
          default: return ST_UNKNOWN;
        endcase
      end
    endcase
    return ST_OK;
  endfunction

  function automatic out_t predict_item(input in_t it);
    out_t o;
    o = '0;
    o.draw_flag = changed;
    case (it.mode)
      MODE_LOAD: ram[it.load_address % RAM_BYTES] = it.load_byte;
      MODE_STEP: begin
        o.opcode = {ram[pc % RAM_BYTES], ram[(pc + 1) % RAM_BYTES]};
        pc = pc + 12'd2;
        o.status = exec_op(o.opcode, it);
        if (sound_t != 0) sound_t--;
        if (delay_t != 0) delay_t--;
        o.draw_flag = changed;
      end
      MODE_READ: begin
        o.row_bits = frame[it.row_index];
        if (it.row_index == 0) changed = 1'b0;
      end
      default: ;
    endcase
    o.program_counter = pc;
    o.sound_on = sound_t != 0;
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int a = 0; a < RAM_BYTES; a++) ram[a] <= (a < FONT_BYTES) ? FONT_ROM[a] : 8'd0;
      for (int r = 0; r < 32; r++) frame[r] <= '0;
      for (int r = 0; r < 16; r++) vreg[r] <= '0;
      for (int r = 0; r < STACK_DEPTH; r++) ret_stack[r] <= '0;
      depth <= 0; pc <= START_PC; idx <= '0;
      delay_t <= '0; sound_t <= '0; changed <= 1'b0;
      expected_q.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      // blocking updates: predictor state is private to this process
      if (done) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          want = expected_q.pop_front();
          if (want !== result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pc=%h op=%h df=%b snd=%b row=%h st=%0d | got pc=%h op=%h df=%b snd=%b row=%h st=%0d",
                want.program_counter, want.opcode, want.draw_flag, want.sound_on,
                want.row_bits, want.status, result.program_counter, result.opcode,
                result.draw_flag, result.sound_on, result.row_bits, result.status);
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_item(item));
      fail_count <= mismatches;
    end
  end

endmodule

@@ bench/tb_chip8_cpu_core.sv @@
// Testbench top for the CHIP-8 core: stimulus, watchdog and verdict.
module tb_chip8_cpu_core;
  import c8cpu_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic busy, done;
  out_t result;
  int   fail_count, pending;
  int   idle_cycles;

  always #6 clk = ~clk;

  chip8_cpu_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  chip8_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_t rand_fields();
    in_t it;
    it.mode = MODE_STEP;
    it.load_address = $urandom;
    it.load_byte = $urandom;
    it.row_index = $urandom;
    it.key_code = $urandom;
    it.key_down = $urandom;
    it.random_byte = $urandom;
    return it;
  endfunction

  // Drives one item and holds it until the core takes it; the core is busy
  // in the cycle after that, so the task lowers start and waits out that cycle.
  task automatic send(input in_t it);
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_byte(input logic [11:0] a, input logic [7:0] b);
    in_t it;
    it = rand_fields();
    it.mode = MODE_LOAD; it.load_address = a; it.load_byte = b;
    send(it);
  endtask

  task automatic put_op(input logic [11:0] a, input logic [15:0] op);
    put_byte(a, op[15:8]);
    put_byte(a + 12'd1, op[7:0]);
  endtask

  task automatic step_once(input logic [3:0] key, input logic down);
    in_t it;
    it = rand_fields();
    it.key_code = key; it.key_down = down;
    send(it);
  endtask

  task automatic read_row(input logic [4:0] r);
    in_t it;
    it = rand_fields();
    it.mode = MODE_READ; it.row_index = r;
    send(it);
  endtask

  // Opcodes weighted towards valid instructions, with some undefined ones.
  function automatic logic [15:0] rand_op();
    logic [15:0] op;
    int k;
    op = $urandom;
    k = $urandom_range(0, 19);
    case (k)
      0: op = 16'h00E0;
      1: op = 16'h00EE;
      2: op[15:12] = 4'h2;
      3: op = {4'h8, op[11:4], 4'(($urandom_range(0, 8) == 8) ? 4'hE : $urandom_range(0, 7))};
      4: op = {4'hD, op[11:4], 4'($urandom_range(0, 4))};
      5: op = {4'hF, op[11:8], 8'h33};
      6: op = {4'hF, op[11:8], 8'h55};
      7: op = {4'hF, op[11:8], 8'h65};
      8: op = {4'hF, op[11:8], ($urandom_range(0, 1) ? 8'h15 : 8'h18)};
      9: op = {4'hE, op[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
      10: op = {4'hF, op[11:8], ($urandom_range(0, 1) ? 8'h07 : 8'h1E)};
      11: op = {4'hF, op[11:8], ($urandom_range(0, 1) ? 8'h29 : 8'h0A)};
      12: op = {4'h6, op[11:0]};
      13: op = {4'hA, op[11:0]};
      default: ;
    endcase
    return op;
  endfunction

  in_t it;
  int  gap;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: font draw, collision, BCD, stack, shifts, wrap, keys
    put_op(12'h200, 16'h00E0);
    put_op(12'h202, 16'h603F);
    put_op(12'h204, 16'h611F);
    put_op(12'h206, 16'hF029);
    put_op(12'h208, 16'hD015);
    put_op(12'h20A, 16'hD015);
    put_op(12'h20C, 16'h62FF);
    put_op(12'h20E, 16'hF233);
    put_op(12'h210, 16'h8F2E);
    put_op(12'h212, 16'hF218);
    put_op(12'h214, 16'h00EE);
    put_op(12'h216, 16'hE29E);
    put_op(12'h218, 16'h8F26);
    put_op(12'h21A, 16'h8008);
    put_op(12'h21C, 16'hBFFF);
    for (int i = 0; i < 15; i++) step_once(4'hF, 1'b1);
    read_row(5'd0);
    read_row(5'd31);
    put_byte(12'hFFF, 8'hFF);
    put_byte(12'h000, 8'h00);
    // deep stack: self-calls overflow, then returns underflow
    put_op(12'h400, 16'h2400);
    put_op(12'h200, 16'h1400);
    step_once(4'h0, 1'b0);
    for (int i = 0; i < 18; i++) step_once(4'h0, 1'b0);
    put_op(12'h400, 16'h00EE);
    for (int i = 0; i < 18; i++) step_once(4'h0, 1'b0);
    while (pending != 0) @(posedge clk);

    // random: program a small area, run it, read rows; bursts with gaps
    for (int n = 0; n < 2000; ) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
      repeat (gap) @(posedge clk);
      for (int b = $urandom_range(1, 12); b > 0; b--, n++) begin
        it = rand_fields();
        case ($urandom_range(0, 9))
          0, 1: begin
            it.mode = MODE_LOAD;
            if ($urandom_range(0, 3) != 0) it.load_address = 12'h200 + 12'($urandom_range(0, 63));
          end
          2: it.mode = MODE_READ;
          3: begin
            put_op(12'h200 + 12'($urandom_range(0, 31) * 2), rand_op());
            n += 2;
          end
          4: begin
            it.mode = MODE_STEP;
            if ($urandom_range(0, 1)) begin
              put_op(it.load_address & 12'hFFE, rand_op());
              n += 2;
            end
          end
          default: it.mode = MODE_STEP;
        endcase
        if (it.mode == MODE_STEP && $urandom_range(0, 1)) it.key_code = $urandom_range(0, 3);
        send(it);
      end
      if (n % 500 < 12) while (pending != 0) @(posedge clk);
    end

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
